// ===== rtl/arbb_pkg.sv =====
// ----------------------------------------------------------------------------
// arbb_pkg: shared types for the affine rectangle bounding box unit
// Coordinate widths, configuration register indexes, port words and the
// words passed between pipeline stages.
// ----------------------------------------------------------------------------
package arbb_pkg;

	localparam int CoordWidth = 32;
	localparam int ExtWidth   = CoordWidth - 1;
	localparam int ProdWidth  = 2 * CoordWidth;
	localparam int SumWidth   = ProdWidth + 2;
	localparam int CfgIdxWidth = 3;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic        [ExtWidth-1:0]   ext_t;
	typedef logic signed [ProdWidth-1:0]  prod_t;
	typedef logic signed [SumWidth-1:0]   wide_t;
	typedef logic        [CfgIdxWidth-1:0] cfg_idx_t;

	localparam coord_t CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
	localparam coord_t CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};
	localparam ext_t   ExtMax   = {ExtWidth{1'b1}};

	localparam cfg_idx_t CfgCoeffA  = 3'd0;
	localparam cfg_idx_t CfgCoeffB  = 3'd1;
	localparam cfg_idx_t CfgCoeffC  = 3'd2;
	localparam cfg_idx_t CfgCoeffD  = 3'd3;
	localparam cfg_idx_t CfgOffsetE = 3'd4;
	localparam cfg_idx_t CfgOffsetF = 3'd5;

	typedef struct packed {
		coord_t rect_x;
		coord_t rect_y;
		coord_t rect_width;
		coord_t rect_height;
	} rect_t;

	typedef struct packed {
		coord_t box_x;
		coord_t box_y;
		ext_t   box_width;
		ext_t   box_height;
		logic   saturated;
	} box_t;

	typedef struct packed {
		coord_t coeff_a;
		coord_t coeff_b;
		coord_t coeff_c;
		coord_t coeff_d;
		coord_t offset_e;
		coord_t offset_f;
	} coeffs_t;

	// stage 1: corner coordinates
	typedef struct packed {
		coord_t x0;
		coord_t x1;
		coord_t y0;
		coord_t y1;
		logic   sat;
	} corners_t;

	// stage 2: exact products, not yet scaled
	typedef struct packed {
		prod_t ax0;
		prod_t ax1;
		prod_t cy0;
		prod_t cy1;
		prod_t bx0;
		prod_t bx1;
		prod_t dy0;
		prod_t dy1;
		logic  sat;
	} prods_t;

	// stage 3: mapped corners
	typedef struct packed {
		coord_t [3:0] px;
		coord_t [3:0] py;
		logic         sat;
	} mapped_t;

	// stage 4: box limits
	typedef struct packed {
		coord_t min_x;
		coord_t max_x;
		coord_t min_y;
		coord_t max_y;
		logic   sat;
	} bounds_t;

	typedef struct packed {
		coord_t value;
		logic   clamped;
	} clamp_t;

	// Saturate a wide sum to the coordinate range.
	function automatic clamp_t clamp_coord(input wide_t v);
		logic [SumWidth-CoordWidth:0] top;
		clamp_t r;
		top = v[SumWidth-1:CoordWidth-1];
		r.clamped = ~((&top) | (~|top));
		if (!r.clamped) begin
			r.value = v[CoordWidth-1:0];
		end else if (v[SumWidth-1]) begin
			r.value = CoordMin;
		end else begin
			r.value = CoordMax;
		end
		return r;
	endfunction

endpackage

// ===== rtl/arbb_cfg.sv =====
// ----------------------------------------------------------------------------
// arbb_cfg: matrix register file
// Six coefficient registers written through the configuration channel.
// Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module arbb_cfg #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  arbb_pkg::cfg_idx_t   cfg_index,
	input  arbb_pkg::coord_t     cfg_data,
	output arbb_pkg::coeffs_t    coeffs
);

	localparam arbb_pkg::coord_t One = arbb_pkg::coord_t'(1) << FRAC_BITS;

	arbb_pkg::coeffs_t coeffs_q;

	assign cfg_ready = 1'b1;
	assign coeffs    = coeffs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeffs_q.coeff_a  <= One;
			coeffs_q.coeff_b  <= '0;
			coeffs_q.coeff_c  <= '0;
			coeffs_q.coeff_d  <= One;
			coeffs_q.offset_e <= '0;
			coeffs_q.offset_f <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				arbb_pkg::CfgCoeffA:  coeffs_q.coeff_a  <= cfg_data;
				arbb_pkg::CfgCoeffB:  coeffs_q.coeff_b  <= cfg_data;
				arbb_pkg::CfgCoeffC:  coeffs_q.coeff_c  <= cfg_data;
				arbb_pkg::CfgCoeffD:  coeffs_q.coeff_d  <= cfg_data;
				arbb_pkg::CfgOffsetE: coeffs_q.offset_e <= cfg_data;
				arbb_pkg::CfgOffsetF: coeffs_q.offset_f <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/arbb_mul.sv =====
// ----------------------------------------------------------------------------
// arbb_mul: corner and product stages
// Stage 1 forms the far corner with saturation, stage 2 forms the eight
// distinct coefficient by coordinate products.
// ----------------------------------------------------------------------------
module arbb_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  arbb_pkg::rect_t     rect,
	input  arbb_pkg::coeffs_t   coeffs,
	output logic                prod_valid,
	output arbb_pkg::prods_t    prods
);

	logic                valid_s1;
	arbb_pkg::corners_t  corn_s1;
	logic                valid_s2;
	arbb_pkg::prods_t    prod_s2;

	arbb_pkg::clamp_t    far_x;
	arbb_pkg::clamp_t    far_y;

	always_comb begin
		far_x = arbb_pkg::clamp_coord(arbb_pkg::wide_t'(rect.rect_x)
			+ arbb_pkg::wide_t'(rect.rect_width));
		far_y = arbb_pkg::clamp_coord(arbb_pkg::wide_t'(rect.rect_y)
			+ arbb_pkg::wide_t'(rect.rect_height));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			corn_s1.x0  <= rect.rect_x;
			corn_s1.y0  <= rect.rect_y;
			corn_s1.x1  <= far_x.value;
			corn_s1.y1  <= far_y.value;
			corn_s1.sat <= far_x.clamped | far_y.clamped;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2.ax0 <= arbb_pkg::prod_t'(coeffs.coeff_a) * arbb_pkg::prod_t'(corn_s1.x0);
			prod_s2.ax1 <= arbb_pkg::prod_t'(coeffs.coeff_a) * arbb_pkg::prod_t'(corn_s1.x1);
			prod_s2.cy0 <= arbb_pkg::prod_t'(coeffs.coeff_c) * arbb_pkg::prod_t'(corn_s1.y0);
			prod_s2.cy1 <= arbb_pkg::prod_t'(coeffs.coeff_c) * arbb_pkg::prod_t'(corn_s1.y1);
			prod_s2.bx0 <= arbb_pkg::prod_t'(coeffs.coeff_b) * arbb_pkg::prod_t'(corn_s1.x0);
			prod_s2.bx1 <= arbb_pkg::prod_t'(coeffs.coeff_b) * arbb_pkg::prod_t'(corn_s1.x1);
			prod_s2.dy0 <= arbb_pkg::prod_t'(coeffs.coeff_d) * arbb_pkg::prod_t'(corn_s1.y0);
			prod_s2.dy1 <= arbb_pkg::prod_t'(coeffs.coeff_d) * arbb_pkg::prod_t'(corn_s1.y1);
			prod_s2.sat <= corn_s1.sat;
		end
	end

	assign prod_valid = valid_s2;
	assign prods      = prod_s2;

endmodule

// ===== rtl/arbb_map.sv =====
// ----------------------------------------------------------------------------
// arbb_map: mapped corner stage
// Floors each product, adds the pair and the offset exactly, then
// saturates each mapped coordinate once.
// ----------------------------------------------------------------------------
module arbb_map #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                prod_valid,
	input  arbb_pkg::prods_t    prods,
	input  arbb_pkg::coeffs_t   coeffs,
	output logic                map_valid,
	output arbb_pkg::mapped_t   mapped
);

	logic               valid_s3;
	arbb_pkg::mapped_t  map_s3;

	arbb_pkg::wide_t    ax0, ax1, cy0, cy1, bx0, bx1, dy0, dy1, e_w, f_w;
	arbb_pkg::clamp_t   cx [4];
	arbb_pkg::clamp_t   cyy [4];

	// arithmetic shift floors toward negative infinity
	always_comb begin
		ax0 = arbb_pkg::wide_t'(prods.ax0 >>> FRAC_BITS);
		ax1 = arbb_pkg::wide_t'(prods.ax1 >>> FRAC_BITS);
		cy0 = arbb_pkg::wide_t'(prods.cy0 >>> FRAC_BITS);
		cy1 = arbb_pkg::wide_t'(prods.cy1 >>> FRAC_BITS);
		bx0 = arbb_pkg::wide_t'(prods.bx0 >>> FRAC_BITS);
		bx1 = arbb_pkg::wide_t'(prods.bx1 >>> FRAC_BITS);
		dy0 = arbb_pkg::wide_t'(prods.dy0 >>> FRAC_BITS);
		dy1 = arbb_pkg::wide_t'(prods.dy1 >>> FRAC_BITS);
		e_w = arbb_pkg::wide_t'(coeffs.offset_e);
		f_w = arbb_pkg::wide_t'(coeffs.offset_f);

		// corners: (x0,y0) (x1,y0) (x1,y1) (x0,y1)
		cx[0]  = arbb_pkg::clamp_coord(ax0 + cy0 + e_w);
		cx[1]  = arbb_pkg::clamp_coord(ax1 + cy0 + e_w);
		cx[2]  = arbb_pkg::clamp_coord(ax1 + cy1 + e_w);
		cx[3]  = arbb_pkg::clamp_coord(ax0 + cy1 + e_w);
		cyy[0] = arbb_pkg::clamp_coord(bx0 + dy0 + f_w);
		cyy[1] = arbb_pkg::clamp_coord(bx1 + dy0 + f_w);
		cyy[2] = arbb_pkg::clamp_coord(bx1 + dy1 + f_w);
		cyy[3] = arbb_pkg::clamp_coord(bx0 + dy1 + f_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= prod_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prod_valid) begin
			for (int i = 0; i < 4; i++) begin
				map_s3.px[i] <= cx[i].value;
				map_s3.py[i] <= cyy[i].value;
			end
			map_s3.sat <= prods.sat | cx[0].clamped | cx[1].clamped | cx[2].clamped
				| cx[3].clamped | cyy[0].clamped | cyy[1].clamped | cyy[2].clamped
				| cyy[3].clamped;
		end
	end

	assign map_valid = valid_s3;
	assign mapped    = map_s3;

endmodule

// ===== rtl/arbb_box.sv =====
// ----------------------------------------------------------------------------
// arbb_box: bounding box stages
// Stage 4 finds the limits of the four mapped corners, stage 5 forms the
// saturated extents and registers the result word, which done marks for one cycle.
// ----------------------------------------------------------------------------
module arbb_box (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                map_valid,
	input  arbb_pkg::mapped_t   mapped,
	output logic                done,
	output arbb_pkg::box_t      box
);

	logic               valid_s4;
	arbb_pkg::bounds_t  bnd_s4;
	logic               valid_s5;
	arbb_pkg::box_t     box_s5;

	arbb_pkg::coord_t   lo_x01, lo_x23, hi_x01, hi_x23;
	arbb_pkg::coord_t   lo_y01, lo_y23, hi_y01, hi_y23;
	arbb_pkg::bounds_t  bnd;

	logic signed [arbb_pkg::CoordWidth:0] dx, dy;
	logic                                 clip_w, clip_h;

	function automatic arbb_pkg::coord_t smin(input arbb_pkg::coord_t p,
		input arbb_pkg::coord_t q);
		return ($signed(q) < $signed(p)) ? q : p;
	endfunction

	function automatic arbb_pkg::coord_t smax(input arbb_pkg::coord_t p,
		input arbb_pkg::coord_t q);
		return ($signed(q) > $signed(p)) ? q : p;
	endfunction

	always_comb begin
		lo_x01 = smin(mapped.px[0], mapped.px[1]);
		lo_x23 = smin(mapped.px[2], mapped.px[3]);
		hi_x01 = smax(mapped.px[0], mapped.px[1]);
		hi_x23 = smax(mapped.px[2], mapped.px[3]);
		lo_y01 = smin(mapped.py[0], mapped.py[1]);
		lo_y23 = smin(mapped.py[2], mapped.py[3]);
		hi_y01 = smax(mapped.py[0], mapped.py[1]);
		hi_y23 = smax(mapped.py[2], mapped.py[3]);
		bnd.min_x = smin(lo_x01, lo_x23);
		bnd.max_x = smax(hi_x01, hi_x23);
		bnd.min_y = smin(lo_y01, lo_y23);
		bnd.max_y = smax(hi_y01, hi_y23);
		bnd.sat   = mapped.sat;
	end

	// extent is never negative; the bit below the sign flags overflow
	always_comb begin
		dx = (arbb_pkg::CoordWidth+1)'(bnd_s4.max_x) - (arbb_pkg::CoordWidth+1)'(bnd_s4.min_x);
		dy = (arbb_pkg::CoordWidth+1)'(bnd_s4.max_y) - (arbb_pkg::CoordWidth+1)'(bnd_s4.min_y);
		clip_w = dx[arbb_pkg::CoordWidth-1];
		clip_h = dy[arbb_pkg::CoordWidth-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= map_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (map_valid) begin
			bnd_s4 <= bnd;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			box_s5.box_x      <= bnd_s4.min_x;
			box_s5.box_y      <= bnd_s4.min_y;
			box_s5.box_width  <= clip_w ? arbb_pkg::ExtMax : dx[arbb_pkg::ExtWidth-1:0];
			box_s5.box_height <= clip_h ? arbb_pkg::ExtMax : dy[arbb_pkg::ExtWidth-1:0];
			box_s5.saturated  <= bnd_s4.sat | clip_w | clip_h;
		end
	end

	assign done = valid_s5;
	assign box  = box_s5;

endmodule

// ===== rtl/affine_rect_bounding_box_unit.sv =====
// ----------------------------------------------------------------------------
// affine_rect_bounding_box_unit: bounding box of an affine-mapped rectangle
// Throughput: one rectangle per cycle; busy stays low, the five-stage
// pipeline (corners, products, mapped sums, limits, extents) never stalls.
// Reset: pipeline valid bits clear, matrix returns to identity.
// Each result word is shown for exactly one cycle with done high.
// ----------------------------------------------------------------------------
module affine_rect_bounding_box_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  arbb_pkg::rect_t     rect,
	output logic                done,
	output arbb_pkg::box_t      box,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  arbb_pkg::cfg_idx_t  cfg_index,
	input  arbb_pkg::coord_t    cfg_data
);

	arbb_pkg::coeffs_t  coeffs;
	logic               in_valid;
	logic               prod_valid;
	arbb_pkg::prods_t   prods;
	logic               map_valid;
	arbb_pkg::mapped_t  mapped;

	assign busy     = 1'b0;
	assign in_valid = start & ~busy;

	arbb_cfg #(
		.FRAC_BITS (FRAC_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coeffs    (coeffs)
	);

	arbb_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.rect       (rect),
		.coeffs     (coeffs),
		.prod_valid (prod_valid),
		.prods      (prods)
	);

	arbb_map #(
		.FRAC_BITS (FRAC_BITS)
	) u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.prod_valid (prod_valid),
		.prods      (prods),
		.coeffs     (coeffs),
		.map_valid  (map_valid),
		.mapped     (mapped)
	);

	arbb_box u_box (
		.clk       (clk),
		.arst_n    (arst_n),
		.map_valid (map_valid),
		.mapped    (mapped),
		.done      (done),
		.box       (box)
	);

endmodule

// ===== tb/bbox_checker.sv =====
// ----------------------------------------------------------------------------
// bbox_checker: predicts and checks bounding box words
// Tracks the matrix through register writes, computes the box of every
// accepted rectangle and compares each done word, field by field, against
// the oldest pending prediction.
// ----------------------------------------------------------------------------
module bbox_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  arbb_pkg::rect_t    rect,
	input  logic               done,
	input  arbb_pkg::box_t     box,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  arbb_pkg::cfg_idx_t cfg_index,
	input  arbb_pkg::coord_t   cfg_data,
	output int                 mismatches,
	output int                 boxes_due
);
	import arbb_pkg::*;

	typedef logic signed [65:0] acc_t;

	localparam acc_t   AccMax = (acc_t'(1) <<< (CoordWidth - 1)) - 1;
	localparam acc_t   AccMin = -(acc_t'(1) <<< (CoordWidth - 1));
	localparam coord_t One    = coord_t'(1) <<< FRAC_BITS;

	coeffs_t matrix;
	box_t    expected_boxes[$];
	int      n_predicted;
	int      n_checked;

	assign boxes_due = n_predicted - n_checked;

	initial mismatches = 0;

	function automatic clamp_t clip(input acc_t v);
		clamp_t r;
		r.clamped = (v > AccMax) || (v < AccMin);
		if (v > AccMax) begin
			r.value = CoordMax;
		end else if (v < AccMin) begin
			r.value = CoordMin;
		end else begin
			r.value = v[CoordWidth-1:0];
		end
		return r;
	endfunction

	// k1*u + k2*v + off, each product floored to the grid before the sum
	function automatic clamp_t map_axis(input coord_t k1, input coord_t u,
			input coord_t k2, input coord_t v, input coord_t off);
		prod_t p1;
		prod_t p2;
		acc_t  acc;
		p1  = k1 * u;
		p2  = k2 * v;
		acc = (p1 >>> FRAC_BITS) + (p2 >>> FRAC_BITS) + off;
		return clip(acc);
	endfunction

	function automatic box_t bounding_box(input rect_t r, input coeffs_t m);
		acc_t   far_x;
		acc_t   far_y;
		acc_t   span_x;
		acc_t   span_y;
		clamp_t x1;
		clamp_t y1;
		clamp_t px;
		clamp_t py;
		coord_t cx[4];
		coord_t cy[4];
		coord_t lo_x;
		coord_t hi_x;
		coord_t lo_y;
		coord_t hi_y;
		logic   sat;
		box_t   b;
		far_x = r.rect_x + r.rect_width;
		far_y = r.rect_y + r.rect_height;
		x1    = clip(far_x);
		y1    = clip(far_y);
		sat   = x1.clamped | y1.clamped;
		cx    = '{r.rect_x, x1.value, x1.value, r.rect_x};
		cy    = '{r.rect_y, r.rect_y, y1.value, y1.value};
		lo_x  = '0;
		hi_x  = '0;
		lo_y  = '0;
		hi_y  = '0;
		for (int i = 0; i < 4; i++) begin
			px  = map_axis(m.coeff_a, cx[i], m.coeff_c, cy[i], m.offset_e);
			py  = map_axis(m.coeff_b, cx[i], m.coeff_d, cy[i], m.offset_f);
			sat = sat | px.clamped | py.clamped;
			if (i == 0 || px.value < lo_x) lo_x = px.value;
			if (i == 0 || px.value > hi_x) hi_x = px.value;
			if (i == 0 || py.value < lo_y) lo_y = py.value;
			if (i == 0 || py.value > hi_y) hi_y = py.value;
		end
		span_x = hi_x - lo_x;
		span_y = hi_y - lo_y;
		if (span_x > AccMax) begin
			span_x = AccMax;
			sat    = 1'b1;
		end
		if (span_y > AccMax) begin
			span_y = AccMax;
			sat    = 1'b1;
		end
		b.box_x      = lo_x;
		b.box_y      = lo_y;
		b.box_width  = span_x[ExtWidth-1:0];
		b.box_height = span_y[ExtWidth-1:0];
		b.saturated  = sat;
		return b;
	endfunction

	task automatic compare_box(input box_t want, input box_t got);
		if (got.box_x !== want.box_x) begin
			$error("box_x: expected %0d, got %0d", want.box_x, got.box_x);
			mismatches++;
		end
		if (got.box_y !== want.box_y) begin
			$error("box_y: expected %0d, got %0d", want.box_y, got.box_y);
			mismatches++;
		end
		if (got.box_width !== want.box_width) begin
			$error("box_width: expected %0d, got %0d", want.box_width, got.box_width);
			mismatches++;
		end
		if (got.box_height !== want.box_height) begin
			$error("box_height: expected %0d, got %0d", want.box_height, got.box_height);
			mismatches++;
		end
		if (got.saturated !== want.saturated) begin
			$error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix      <= coeffs_t'{One, coord_t'(0), coord_t'(0), One,
				coord_t'(0), coord_t'(0)};
			n_predicted <= 0;
			n_checked   <= 0;
			expected_boxes.delete();
		end else begin
			if (done) begin
				if (expected_boxes.size() == 0) begin
					$error("box word with no rectangle pending");
					mismatches++;
				end else begin
					compare_box(expected_boxes.pop_front(), box);
					n_checked <= n_checked + 1;
				end
			end
			if (start && !busy) begin
				expected_boxes.push_back(bounding_box(rect, matrix));
				n_predicted <= n_predicted + 1;
			end
			// indexes past the last register are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CfgCoeffA:  matrix.coeff_a  <= cfg_data;
					CfgCoeffB:  matrix.coeff_b  <= cfg_data;
					CfgCoeffC:  matrix.coeff_c  <= cfg_data;
					CfgCoeffD:  matrix.coeff_d  <= cfg_data;
					CfgOffsetE: matrix.offset_e <= cfg_data;
					CfgOffsetF: matrix.offset_f <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: affine rectangle bounding box unit
// Directed corner rectangles under the reset matrix and under extreme
// matrices, then random phases that each rewrite a random subset of the
// registers with the pipeline empty. Sender gaps vary per stretch of words.
// ----------------------------------------------------------------------------
module testbench;
	import arbb_pkg::*;

	localparam int       FracBits      = 16;
	localparam int       WatchdogLimit = 2000;
	localparam int       RandomPhases  = 10;
	localparam int       RectsPerPhase = 145;
	localparam int       GapMax        = 17;
	localparam cfg_idx_t CfgSpareLo    = cfg_idx_t'(CfgOffsetF + 1);
	localparam cfg_idx_t CfgSpareHi    = cfg_idx_t'(CfgOffsetF + 2);
	localparam coord_t   One           = coord_t'(1) <<< FracBits;
	localparam coord_t   Half          = One >>> 1;

	typedef enum int {
		GapsNone,
		GapsFull,
		GapsSparse
	} gap_mode_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	rect_t     rect;
	logic      done;
	box_t      box;
	logic      cfg_valid;
	logic      cfg_ready;
	cfg_idx_t  cfg_index;
	coord_t    cfg_data;
	int        mismatches;
	int        boxes_due;
	int        idle_cycles = 0;
	gap_mode_t gap_mode = GapsNone;

	affine_rect_bounding_box_unit #(
		.FRAC_BITS(FracBits)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.rect     (rect),
		.done     (done),
		.box      (box),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	bbox_checker #(
		.FRAC_BITS(FracBits)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.rect      (rect),
		.done      (done),
		.box       (box),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.boxes_due (boxes_due)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WatchdogLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int draw_gap();
		case (gap_mode)
			GapsNone: return 0;
			GapsFull: return $urandom_range(0, GapMax);
			default:  return ($urandom_range(0, 7) == 0) ? $urandom_range(1, GapMax) : 0;
		endcase
	endfunction

	// small coordinates so mapped boxes stay in range, plus edges and random words
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 11))
			0:             return CoordMax;
			1:             return CoordMin;
			2:             return coord_t'(0);
			3:             return coord_t'(-1);
			4, 5, 6, 7, 8: return coord_t'(int'($urandom_range(0, 32'h3f_ffff)) - 32'sh20_0000);
			default:       return coord_t'($urandom());
		endcase
	endfunction

	function automatic coord_t pick_coeff();
		case ($urandom_range(0, 11))
			0:             return CoordMax;
			1:             return CoordMin;
			2:             return coord_t'(0);
			3:             return One;
			4:             return -One;
			5, 6, 7, 8, 9: return coord_t'(int'($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000);
			default:       return coord_t'($urandom());
		endcase
	endfunction

	// start stays high across back-to-back words
	task automatic send_rect(input rect_t r);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		rect  <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input coord_t value);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic drain();
		start     <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (boxes_due != 0) @(posedge clk);
	endtask

	task automatic load_matrix(input coord_t a, input coord_t b, input coord_t c,
			input coord_t d, input coord_t e, input coord_t f);
		drain();
		write_reg(CfgCoeffA, a);
		write_reg(CfgCoeffB, b);
		write_reg(CfgCoeffC, c);
		write_reg(CfgCoeffD, d);
		write_reg(CfgOffsetE, e);
		write_reg(CfgOffsetF, f);
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		start     = 1'b0;
		rect      = '0;
		cfg_valid = 1'b0;
		cfg_index = CfgCoeffA;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset matrix: identity
		gap_mode = GapsFull;
		send_rect('{coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0)});
		send_rect('{CoordMax, CoordMax, CoordMax, CoordMax});
		send_rect('{CoordMin, CoordMin, CoordMin, CoordMin});
		send_rect('{CoordMax, CoordMin, CoordMin, CoordMax});
		send_rect('{One * 5, One * 3, -One * 2, -One * 7});
		send_rect('{coord_t'(-1), coord_t'(-1), coord_t'(1), coord_t'(1)});
		send_rect('{Half, -Half, Half + 1, -Half - 1});
		send_rect('{CoordMin, CoordMax, coord_t'(-1), coord_t'(1)});

		// extreme matrices; spare indexes must not disturb them
		load_matrix(CoordMax, CoordMin, CoordMin, CoordMax, CoordMax, CoordMin);
		write_reg(CfgSpareLo, CoordMin);
		write_reg(CfgSpareHi, coord_t'(0));
		cfg_valid <= 1'b0;
		send_rect('{CoordMax, CoordMax, CoordMin, CoordMin});
		send_rect('{coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0)});
		send_rect('{One, -One, Half, -Half});

		load_matrix(CoordMin, CoordMax, CoordMax, CoordMin, CoordMin, CoordMax);
		cfg_valid <= 1'b0;
		send_rect('{CoordMin, CoordMin, CoordMax, CoordMax});
		send_rect('{coord_t'(1), coord_t'(-1), coord_t'(0), coord_t'(0)});
		send_rect('{-One, One, One * 3, One * 2});

		// mirror, shear and stretch with an offset
		load_matrix(-One, Half, -Half, One * 2, One * 100, -One * 100);
		cfg_valid <= 1'b0;
		send_rect('{One * 10, One * 20, -One * 4, One * 6});
		send_rect('{-One * 7, Half, One * 9, -One * 3});
		send_rect('{CoordMax, CoordMin, coord_t'(0), coord_t'(0)});
		send_rect('{Half + 1, -Half - 1, Half, Half});

		for (int ph = 0; ph < RandomPhases; ph++) begin
			drain();
			for (int i = int'(CfgCoeffA); i <= int'(CfgSpareHi); i++) begin
				if ($urandom_range(0, 3) != 0) begin
					write_reg(cfg_idx_t'(i), (i >= int'(CfgOffsetE)) ? pick_coord() : pick_coeff());
				end
			end
			cfg_valid <= 1'b0;
			for (int n = 0; n < RectsPerPhase; n++) begin
				if (n % 29 == 0) gap_mode = gap_mode_t'($urandom_range(0, 2));
				send_rect('{pick_coord(), pick_coord(), pick_coord(), pick_coord()});
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && boxes_due == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/arbb_pkg.sv
rtl/arbb_cfg.sv
rtl/arbb_mul.sv
rtl/arbb_map.sv
rtl/arbb_box.sv
rtl/affine_rect_bounding_box_unit.sv
tb/bbox_checker.sv
tb/testbench.sv
